FILE: src/mcpf_pkg.sv
// Shared types and constants for the multi-channel PWM with pattern fill.
package mcpf_pkg;

   localparam int ACTION_W = 2;
   localparam int DUTY_W   = 8;
   localparam int VEC_W    = 16;

   localparam logic [DUTY_W-1:0] PHASE_STEP_RESET = 8'd8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_COLOR = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef struct packed {
      logic shift;
      logic use_head;
   } fill_ctrl_type;

endpackage

FILE: src/mcpf_cell.sv
// One channel cell: duty threshold storage, compare against phase, link to neighbor.
module mcpf_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        wr_en,
   input  logic [mcpf_pkg::DUTY_W-1:0] wr_data,
   input  logic                        shift,
   input  logic [mcpf_pkg::DUTY_W-1:0] shift_data,
   input  logic [mcpf_pkg::DUTY_W-1:0] phase,
   output logic [mcpf_pkg::DUTY_W-1:0] duty,
   output logic                        on
);
   import mcpf_pkg::*;

   logic [DUTY_W-1:0] duty_ff;
   logic [DUTY_W-1:0] duty_in;

   always_comb begin
      duty_in = duty_ff;
      if (clear) begin
         duty_in = '0;
      end else if (shift) begin
         duty_in = shift_data;
      end else if (wr_en) begin
         duty_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else begin
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;
   assign on   = (duty_ff > phase);

endmodule

FILE: src/mcpf_fill.sv
// Pattern repeat sequencer: rotates the cell chain once around after a short pattern.
module mcpf_fill #(
   parameter int CHANNELS = 16,
   parameter int FW       = 5,
   parameter int IW       = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [FW-1:0]           pat_len,
   output mcpf_pkg::fill_ctrl_type ctrl,
   output logic [IW-1:0]           tap_idx
);
   import mcpf_pkg::*;

   localparam logic [FW-1:0] CHAN_F = FW'(CHANNELS);
   localparam logic [FW-1:0] LAST_STEP = FW'(CHANNELS - 1);

   logic          busy_ff;
   logic          busy_in;
   logic [FW-1:0] step_ff;
   logic [FW-1:0] step_in;
   logic [FW-1:0] len_ff;
   logic [FW-1:0] len_in;
   logic [FW-1:0] tap_full;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      len_in  = len_ff;
      if (busy_ff) begin
         step_in = step_ff + FW'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end else if (start && (pat_len != CHAN_F) && (pat_len != '0)) begin
         busy_in = 1'b1;
         step_in = '0;
         len_in  = pat_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         len_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         len_ff  <= len_in;
      end
   end

   assign tap_full      = CHAN_F - len_ff;
   assign tap_idx       = tap_full[IW-1:0];
   assign ctrl.shift    = busy_ff;
   assign ctrl.use_head = (step_ff < len_ff);

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (len_ff != '0) && (len_ff < CHAN_F))
      else $error("fill running with an invalid pattern length");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= LAST_STEP)
      else $error("fill step past last channel");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff != LAST_STEP) |=> busy_ff && (step_ff == $past(step_ff) + FW'(1)))
      else $error("fill ended early or step skipped");

endmodule

FILE: src/multi_channel_pwm_pattern_fill.sv
// Top level: multi-channel PWM with pattern fill, built from a chain of channel cells.
// A tick's on/off vector is on rsp_tdata in the cycle after the request is accepted, if it changed.
// Throughput: one request per cycle while no fill runs and no result waits on rsp_tready.
// A final color leaving a pattern shorter than CHANNELS stalls requests while the
// repeat sequencer rotates the values once around the cell chain.
// Reset (synchronous): thresholds, phase, last vector and fill count zero, phase step 8.
module multi_channel_pwm_pattern_fill #(
   parameter int CHANNELS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] color
   input  logic [1:0]                  req_tuser,   // [1:0] action
   input  logic                        req_tlast,   // pattern_last
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,   // [15:0] channel_bits
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mcpf_pkg::DUTY_W-1:0] csr_data     // phase_step
);
   import mcpf_pkg::*;

   localparam int FW = $clog2(CHANNELS + 1);
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [FW-1:0] CHAN_F = FW'(CHANNELS);

   logic [DUTY_W-1:0] phase_step_ff;
   logic [DUTY_W-1:0] pwm_phase_ff;
   logic [DUTY_W-1:0] pwm_phase_in;
   logic [FW-1:0]     fill_count_ff;
   logic [FW-1:0]     fill_count_in;
   logic [VEC_W-1:0]  last_vector_ff;
   logic [VEC_W-1:0]  last_vector_in;
   logic [VEC_W-1:0]  rsp_data_ff;
   logic [VEC_W-1:0]  rsp_data_in;
   logic              rsp_tvalid_ff;
   logic              rsp_tvalid_in;

   action_type        action;
   logic              req_accept;
   logic              tick;
   logic              color_wr;
   logic              clear_all;
   logic              fill_start;
   logic [FW-1:0]     pat_len;
   fill_ctrl_type     fill_ctrl;
   logic [IW-1:0]     tap_idx;
   logic [DUTY_W-1:0] insert_data;
   logic [VEC_W-1:0]  vec;

   logic [DUTY_W-1:0] duty [CHANNELS];
   logic              on_bit [CHANNELS];

   assign action     = action_type'(req_tuser);
   assign req_tready = !fill_ctrl.shift && (!rsp_tvalid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign tick       = req_accept && (action == ACT_TICK);
   assign color_wr   = req_accept && (action == ACT_COLOR);
   assign clear_all  = req_accept && (action == ACT_CLEAR);
   assign fill_start = color_wr && req_tlast;
   assign pat_len    = (fill_count_ff < CHAN_F) ? fill_count_ff + FW'(1) : fill_count_ff;
   assign csr_ready  = 1'b1;

   assign insert_data = fill_ctrl.use_head ? duty[0] : duty[tap_idx];

   mcpf_fill #(
      .CHANNELS (CHANNELS),
      .FW       (FW),
      .IW       (IW)
   ) u_fill (
      .clock   (clock),
      .reset   (reset),
      .start   (fill_start),
      .pat_len (pat_len),
      .ctrl    (fill_ctrl),
      .tap_idx (tap_idx)
   );

   for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
      logic [DUTY_W-1:0] link;
      if (i == CHANNELS - 1) begin : g_tail
         assign link = insert_data;
      end else begin : g_mid
         assign link = duty[i+1];
      end
      mcpf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (clear_all),
         .wr_en      (color_wr && (fill_count_ff == FW'(i))),
         .wr_data    (req_tdata),
         .shift      (fill_ctrl.shift),
         .shift_data (link),
         .phase      (pwm_phase_ff),
         .duty       (duty[i]),
         .on         (on_bit[i])
      );
   end

   for (genvar b = 0; b < VEC_W; b++) begin : g_vec
      if (b < CHANNELS) begin : g_on
         assign vec[b] = on_bit[b];
      end else begin : g_off
         assign vec[b] = 1'b0;
      end
   end

   always_comb begin
      pwm_phase_in   = pwm_phase_ff;
      fill_count_in  = fill_count_ff;
      last_vector_in = last_vector_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      if (tick) begin
         pwm_phase_in = pwm_phase_ff + phase_step_ff;
         if (vec != last_vector_ff) begin
            last_vector_in = vec;
            rsp_data_in    = vec;
            rsp_tvalid_in  = 1'b1;
         end
      end
      if (color_wr) begin
         if (req_tlast) begin
            fill_count_in = '0;
         end else if (fill_count_ff < CHAN_F) begin
            fill_count_in = fill_count_ff + FW'(1);
         end
      end
      if (clear_all) begin
         fill_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RESET;
         pwm_phase_ff   <= '0;
         fill_count_ff  <= '0;
         last_vector_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            phase_step_ff <= csr_data;
         end
         pwm_phase_ff   <= pwm_phase_in;
         fill_count_ff  <= fill_count_in;
         last_vector_ff <= last_vector_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_data_ff == last_vector_ff)
      else $error("pending result differs from last emitted vector");

   assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CHAN_F)
      else $error("fill count beyond channel count");

   assert property (@(posedge clock) disable iff (reset)
      fill_ctrl.shift |-> (fill_count_ff == '0) && !req_tready)
      else $error("requests open or fill count set during pattern repeat");

   assert property (@(posedge clock) disable iff (reset)
      !tick |=> $stable(pwm_phase_ff))
      else $error("phase moved without a tick");

endmodule
